>>> rtl/core/assert_macros.svh
// Assertion macros shared by the sobel core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SOBEL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define SOBEL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/sobel_pkg.sv
// Shared types and constants of the sobel edge magnitude core.
`timescale 1ns / 1ps
package sobel_pkg;

    localparam int unsigned MaxWidthDef  = 1024;
    localparam int unsigned HeightLimit  = 4096;
    localparam int unsigned CfgWidthRst  = 640;
    localparam int unsigned CfgHeightRst = 480;
    localparam int unsigned CfgAddrW     = 3;
    localparam int unsigned PixW         = 8;
    localparam int unsigned CfgWidthW    = 11;
    localparam int unsigned CfgHeightW   = 13;
    localparam int unsigned LineW        = 2 * PixW;

    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic
    {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

    // Frame geometry handed from the register block to the control.
    typedef struct packed
    {
        logic                    restart;
        logic [CfgHeightW-1:0]   height;
        logic [CfgHeightW-2:0]   height_m1;
    } cfg_ctl_t;

    // What one accepted beat does in the datapath.
    typedef struct packed
    {
        logic update;
        logic emit;
        logic inner;
        logic last;
    } item_ctl_t;

endpackage

>>> rtl/core/sobel_stream_ifs.sv
// Valid/ready stream interfaces for pixel input and magnitude results.
`timescale 1ns / 1ps
interface sobel_pix_if;
    import sobel_pkg::*;

    logic            valid;
    logic            ready;
    logic            kind;
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;

    modport source (output valid, kind, red, green, blue, input ready);
    modport sink   (input valid, kind, red, green, blue, output ready);
endinterface

interface sobel_res_if;
    import sobel_pkg::*;

    logic            valid;
    logic            ready;
    logic [PixW-1:0] magnitude;
    logic            frame_last;

    modport source (output valid, magnitude, frame_last, input ready);
    modport sink   (input valid, magnitude, frame_last, output ready);
endinterface

>>> rtl/core/sobel_line_store.sv
// Two-row line store: one entry per column holds {older row, previous row}.
`timescale 1ns / 1ps
module sobel_line_store #(
    parameter int unsigned MAX_WIDTH = sobel_pkg::MaxWidthDef
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    output logic [sobel_pkg::LineW-1:0]   rd_data,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
    input  logic [sobel_pkg::LineW-1:0]   wr_data
);
    import sobel_pkg::*;

    logic [LineW-1:0] mem [MAX_WIDTH];
    logic [LineW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

>>> rtl/core/sobel_cfg.sv
// APB register block: frame width and height, clamped geometry for the core.
`timescale 1ns / 1ps
module sobel_cfg #(
    parameter int unsigned MAX_WIDTH = sobel_pkg::MaxWidthDef
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sobel_pkg::CfgAddrW-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [$clog2(MAX_WIDTH)-1:0]     width_m1,
    output logic [$clog2(MAX_WIDTH+2)-1:0]   width_p1,
    output sobel_pkg::cfg_ctl_t              cfg
);
    import sobel_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned PW = $clog2(MAX_WIDTH + 2);
    localparam int unsigned EffWRst =
        (CfgWidthRst > MAX_WIDTH) ? MAX_WIDTH : CfgWidthRst;

    logic [CfgWidthW-1:0]  width_raw_reg;
    logic [CfgHeightW-1:0] height_raw_reg;
    logic [CW-1:0]         width_m1_reg;
    logic [PW-1:0]         width_p1_reg;
    logic [CfgHeightW-1:0] height_reg;
    logic [CfgHeightW-2:0] height_m1_reg;

    logic                  wr_en;
    cfg_reg_t              reg_sel;
    logic [CfgHeightW-1:0] eff_w;
    logic [CfgHeightW-1:0] eff_h;

    // zero acts as one, too large acts as the limit
    function automatic logic [CfgHeightW-1:0] clamp_width(input logic [CfgWidthW-1:0] raw);
        logic [CfgHeightW-1:0] ext;
        begin
            ext = {{(CfgHeightW-CfgWidthW){1'b0}}, raw};
            if (raw == '0)
            begin
                clamp_width = CfgHeightW'(1);
            end
            else if (ext > CfgHeightW'(MAX_WIDTH))
            begin
                clamp_width = CfgHeightW'(MAX_WIDTH);
            end
            else
            begin
                clamp_width = ext;
            end
        end
    endfunction

    function automatic logic [CfgHeightW-1:0] clamp_height(input logic [CfgHeightW-1:0] raw);
        begin
            if (raw == '0)
            begin
                clamp_height = CfgHeightW'(1);
            end
            else if (raw > CfgHeightW'(HeightLimit))
            begin
                clamp_height = CfgHeightW'(HeightLimit);
            end
            else
            begin
                clamp_height = raw;
            end
        end
    endfunction

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = cfg_reg_t'(paddr[2]);
    assign eff_w   = clamp_width(pwdata[CfgWidthW-1:0]);
    assign eff_h   = clamp_height(pwdata[CfgHeightW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg  <= CfgWidthW'(CfgWidthRst);
            height_raw_reg <= CfgHeightW'(CfgHeightRst);
            width_m1_reg   <= CW'(EffWRst - 1);
            width_p1_reg   <= PW'(EffWRst + 1);
            height_reg     <= CfgHeightW'(CfgHeightRst);
            height_m1_reg  <= (CfgHeightW-1)'(CfgHeightRst - 1);
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_WIDTH:
                begin
                    width_raw_reg <= pwdata[CfgWidthW-1:0];
                    width_m1_reg  <= CW'(eff_w - CfgHeightW'(1));
                    width_p1_reg  <= PW'(eff_w + CfgHeightW'(1));
                end
                REG_HEIGHT:
                begin
                    height_raw_reg <= pwdata[CfgHeightW-1:0];
                    height_reg     <= eff_h;
                    height_m1_reg  <= (CfgHeightW-1)'(eff_h - CfgHeightW'(1));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_WIDTH:  prdata = {{(32-CfgWidthW){1'b0}}, width_raw_reg};
            REG_HEIGHT: prdata = {{(32-CfgHeightW){1'b0}}, height_raw_reg};
            default:    prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign width_m1      = width_m1_reg;
    assign width_p1      = width_p1_reg;
    assign cfg.restart   = wr_en;
    assign cfg.height    = height_reg;
    assign cfg.height_m1 = height_m1_reg;
endmodule

>>> rtl/core/sobel_ctrl.sv
// Position control: input column/row, result position and the lag of one line plus one pixel.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sobel_ctrl #(
    parameter int unsigned MAX_WIDTH = sobel_pkg::MaxWidthDef
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(MAX_WIDTH)-1:0]     width_m1,
    input  logic [$clog2(MAX_WIDTH+2)-1:0]   width_p1,
    input  sobel_pkg::cfg_ctl_t              cfg,
    input  logic                             accept,
    input  logic                             kind,
    output sobel_pkg::item_ctl_t             item,
    output logic [$clog2(MAX_WIDTH)-1:0]     col
);
    import sobel_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned PW = $clog2(MAX_WIDTH + 2);

    logic [CW-1:0]           col_reg;
    logic [CfgHeightW-1:0]   row_reg;
    logic [PW-1:0]           pend_reg;
    logic [CW-1:0]           ox_reg;
    logic [CfgHeightW-2:0]   oy_reg;

    logic complete;
    logic is_pixel;
    logic emit;
    logic last;

    assign complete = (row_reg >= cfg.height);
    assign is_pixel = (kind == KIND_PIXEL) && !complete;
    // pending count saturates at width+1: from then on every pixel releases one result
    assign emit     = complete || (is_pixel && (pend_reg == width_p1));
    assign last     = (ox_reg == width_m1) && (oy_reg == cfg.height_m1);

    assign item.update = is_pixel;
    assign item.emit   = emit;
    assign item.inner  = (ox_reg != '0) && (ox_reg != width_m1) &&
                         (oy_reg != '0) && (oy_reg != cfg.height_m1);
    assign item.last   = last;
    assign col         = col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
        end
        else if (cfg.restart || (accept && emit && last))
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
        end
        else if (accept)
        begin
            if (is_pixel)
            begin
                if (col_reg == width_m1)
                begin
                    col_reg <= '0;
                    row_reg <= CfgHeightW'(row_reg + 1'b1);
                end
                else
                begin
                    col_reg <= CW'(col_reg + 1'b1);
                end
                if (!emit)
                begin
                    pend_reg <= PW'(pend_reg + 1'b1);
                end
            end
            if (emit)
            begin
                if (ox_reg == width_m1)
                begin
                    ox_reg <= '0;
                    oy_reg <= (CfgHeightW-1)'(oy_reg + 1'b1);
                end
                else
                begin
                    ox_reg <= CW'(ox_reg + 1'b1);
                end
            end
        end
    end

    `SOBEL_NEVER(a_pend_bound, pend_reg > width_p1, "pending count beyond width+1")
    `SOBEL_NEVER(a_col_bound, (col_reg > width_m1) || (ox_reg > width_m1), "column past row end")
    `SOBEL_NEVER(a_row_bound, row_reg > cfg.height, "row count past frame height")
endmodule

>>> rtl/core/sobel_pipe.sv
// Datapath: grey conversion, item stage, 3x3 window, Sobel magnitude, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sobel_pipe #(
    parameter int unsigned MAX_WIDTH = sobel_pkg::MaxWidthDef
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sobel_pix_if.sink                        pixel_in,
    sobel_res_if.source                      result_out,
    input  sobel_pkg::item_ctl_t             item,
    input  logic [$clog2(MAX_WIDTH)-1:0]     col,
    output logic                             accept,
    input  logic [sobel_pkg::LineW-1:0]      ls_rd_data,
    output logic                             ls_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]     ls_wr_addr,
    output logic [sobel_pkg::LineW-1:0]      ls_wr_data
);
    import sobel_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);

    logic            s1_valid_reg;
    item_ctl_t       s1_item_reg;
    logic [CW-1:0]   s1_col_reg;
    logic [PixW-1:0] s1_grey_reg;

    logic [PixW-1:0] window_reg  [9];
    logic [PixW-1:0] window_next [9];

    logic            out_valid_reg;
    logic [PixW-1:0] out_mag_reg;
    logic            out_last_reg;

    logic            out_free;
    logic            s1_move;
    logic [PixW-1:0] grey_in;
    logic [PixW-1:0] prev_row;
    logic [PixW-1:0] older_row;
    logic [PixW-1:0] mag;

    // (r+g+b)/3 as (sum*683)>>11, exact for sums up to 765
    function automatic logic [PixW-1:0] grey_of(input logic [PixW-1:0] r,
                                                input logic [PixW-1:0] g,
                                                input logic [PixW-1:0] b);
        logic [PixW+1:0]  sum;
        logic [PixW+11:0] prod;
        begin
            sum     = (PixW+2)'(r) + (PixW+2)'(g) + (PixW+2)'(b);
            prod    = (PixW+12)'(sum) * (PixW+12)'(683);
            grey_of = prod[PixW+10:11];
        end
    endfunction

    function automatic logic [PixW+1:0] abs_diff(input logic [PixW+1:0] a,
                                                 input logic [PixW+1:0] b);
        begin
            abs_diff = (a >= b) ? (a - b) : (b - a);
        end
    endfunction

    assign out_free       = !out_valid_reg || result_out.ready;
    assign s1_move        = s1_valid_reg && (!s1_item_reg.emit || out_free);
    assign pixel_in.ready = !s1_valid_reg || s1_move;
    assign accept         = pixel_in.valid && pixel_in.ready;
    assign grey_in        = grey_of(pixel_in.red, pixel_in.green, pixel_in.blue);

    assign older_row  = ls_rd_data[LineW-1:PixW];
    assign prev_row   = ls_rd_data[PixW-1:0];
    assign ls_wr_en   = s1_move && s1_item_reg.update;
    assign ls_wr_addr = s1_col_reg;
    assign ls_wr_data = {prev_row, s1_grey_reg};

    always_comb
    begin
        window_next = window_reg;
        if (s1_move && s1_item_reg.update)
        begin
            window_next[0] = window_reg[1];
            window_next[1] = window_reg[2];
            window_next[2] = older_row;
            window_next[3] = window_reg[4];
            window_next[4] = window_reg[5];
            window_next[5] = prev_row;
            window_next[6] = window_reg[7];
            window_next[7] = window_reg[8];
            window_next[8] = s1_grey_reg;
        end
    end

    // |Gx|+|Gy| on the updated window, clamped
    always_comb
    begin
        logic [PixW+1:0] gx_p;
        logic [PixW+1:0] gx_n;
        logic [PixW+1:0] gy_p;
        logic [PixW+1:0] gy_n;
        logic [PixW+2:0] total;
        gx_p  = (PixW+2)'(window_next[2]) + {1'b0, window_next[5], 1'b0} +
                (PixW+2)'(window_next[8]);
        gx_n  = (PixW+2)'(window_next[0]) + {1'b0, window_next[3], 1'b0} +
                (PixW+2)'(window_next[6]);
        gy_p  = (PixW+2)'(window_next[6]) + {1'b0, window_next[7], 1'b0} +
                (PixW+2)'(window_next[8]);
        gy_n  = (PixW+2)'(window_next[0]) + {1'b0, window_next[1], 1'b0} +
                (PixW+2)'(window_next[2]);
        total = (PixW+3)'(abs_diff(gx_p, gx_n)) + (PixW+3)'(abs_diff(gy_p, gy_n));
        mag   = (total > (PixW+3)'(255)) ? PixW'(255) : total[PixW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move && s1_item_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
            s1_col_reg  <= col;
            s1_grey_reg <= grey_in;
        end
        if (s1_move && s1_item_reg.emit)
        begin
            out_mag_reg  <= s1_item_reg.inner ? mag : '0;
            out_last_reg <= s1_item_reg.last;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.magnitude  = out_mag_reg;
    assign result_out.frame_last = out_last_reg;

    // the final pixel of a frame is a corner, so its magnitude is zero
    `SOBEL_ASSERT(a_last_border, (out_valid_reg && out_last_reg) |-> (out_mag_reg == '0), "frame_last beat with nonzero magnitude")
    `SOBEL_ASSERT(a_stall_hold, (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_col_reg)), "item stage lost a stalled beat")
endmodule

>>> rtl/core/sobel_edge_magnitude_stream.sv
// Top level of the streaming 3x3 Sobel edge magnitude core.
`timescale 1ns / 1ps
// Usage:
//   pixel_in   : RGB pixels in raster order, kind = pixel or flush beat.
//   result_out : one clamped |Gx|+|Gy| per frame position, zero on the frame
//                border; frame_last marks the frame's final position.
//   APB port   : image_width at 0x0, image_height at 0x4; a write also
//                restarts the frame. Write only while the core is idle.
// The first image_width+1 pixels of a frame give no beat; after that each
// pixel gives one. Once the frame is complete, each flush (or pixel) beat
// releases one trailing result until frame_last, then a new frame starts.
// A releasing input beat passes the item stage and the result register.
// Throughput: one input beat per cycle unless result_out stalls, set by
// the single line-store read per column and the one-stage window update.
// Reset: width 640, height 480, counters and window cleared; line store
// contents are left as they are and only ever feed border positions.
// When result_out stalls, the result register holds; pixel_in.ready drops
// once the item stage holds a beat that releases a result.
module sobel_edge_magnitude_stream #(
    parameter int unsigned MAX_WIDTH = sobel_pkg::MaxWidthDef
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sobel_pix_if.sink                        pixel_in,
    sobel_res_if.source                      result_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sobel_pkg::CfgAddrW-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import sobel_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned PW = $clog2(MAX_WIDTH + 2);

    logic [CW-1:0]    width_m1;
    logic [PW-1:0]    width_p1;
    cfg_ctl_t         cfg;
    item_ctl_t        item;
    logic [CW-1:0]    col;
    logic             accept;
    logic [LineW-1:0] ls_rd_data;
    logic             ls_wr_en;
    logic [CW-1:0]    ls_wr_addr;
    logic [LineW-1:0] ls_wr_data;

    sobel_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .width_m1 (width_m1),
        .width_p1 (width_p1),
        .cfg      (cfg)
    );

    sobel_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .width_m1 (width_m1),
        .width_p1 (width_p1),
        .cfg      (cfg),
        .accept   (accept),
        .kind     (pixel_in.kind),
        .item     (item),
        .col      (col)
    );

    sobel_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
        .clk      (clk),
        .rd_en    (accept),
        .rd_addr  (col),
        .rd_data  (ls_rd_data),
        .wr_en    (ls_wr_en),
        .wr_addr  (ls_wr_addr),
        .wr_data  (ls_wr_data)
    );

    sobel_pipe #(.MAX_WIDTH(MAX_WIDTH)) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pixel_in),
        .result_out (result_out),
        .item       (item),
        .col        (col),
        .accept     (accept),
        .ls_rd_data (ls_rd_data),
        .ls_wr_en   (ls_wr_en),
        .ls_wr_addr (ls_wr_addr),
        .ls_wr_data (ls_wr_data)
    );
endmodule
